// ----- design/farthest_pair_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Farthest pair search assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FARTHEST_PAIR_SEARCH_TOP_DEFINES_SVH
`define FARTHEST_PAIR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fps checker: same-cycle rule violated");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fps checker: next-cycle rule violated");

`endif

// ----- design/fps_pkg.sv -----
// ----------------------------------------------------------------------------
// Farthest pair search package
// Sizes, packing widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = 2 * COORD_BITS + 1;

    localparam int S_TDATA_W  = 2 * COORD_BITS;
    localparam int M_FIELDS_W = 4 * COORD_BITS + DIST_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;     // store or drop the incoming point
        logic scan_init;   // clear best, start pair walk at (0,1)
        logic scan_run;    // issue the current pair into the pipeline
        logic fetch;       // read the two best points
        logic emit;        // load the output register, empty the set
    } fps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // no pair left to issue
        logic pipe_idle;   // compare pipeline empty
        logic out_free;    // output register can take a result
    } fps_stat_t;

    typedef struct packed {
        logic                 points_dropped;
        logic                 pair_found;
        logic [DIST_W-1:0]    max_dist_sq;
        coord_t               second_y;
        coord_t               second_x;
        coord_t               first_y;
        coord_t               first_x;
    } fps_result_t;

endpackage

`default_nettype wire

// ----- design/farthest_pair_search_top.sv -----
// ----------------------------------------------------------------------------
// Farthest pair search top level
// Loads a set of 2-D points, finds the pair with the largest squared distance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Item                       Accepted when
//  s_*       in         one point, tlast ends set  s_tvalid && s_tready
//  m_*       out        one result per set         m_tvalid && m_tready
//
// Loading stores points up to MAX_POINTS; later ones are dropped and flagged.
// After the last point the scan issues one pair per cycle, N*(N-1)/2 pairs for
// N stored points, set by the two read ports of the point memory feeding a single
// distance/compare pipeline; then the pipeline drains, the best pair is fetched and the output is loaded.
// s_tready is low from the last point until the result is in the output
// register; a stalled result holds there while the next set loads.
// Reset (rst_n low, asynchronous) empties the set and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module farthest_pair_search_top
    import fps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // point input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord
    input  wire logic                 s_tlast,   // last_point
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // first_x, first_y, second_x,
                                                 // second_y, max_dist_sq, zero pad
    output logic [M_TUSER_W-1:0]      m_tuser    // pair_found, points_dropped
);

    fps_cmd_t    cmd;
    fps_stat_t   stat;
    fps_result_t result;

    fps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fps_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_x      (s_tdata[COORD_BITS-1:0]),
        .in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .result    (result),
        .stat      (stat)
    );

    // pack fields from the lowest bit up, pad to whole bytes
    assign m_tdata = {(M_TDATA_W - M_FIELDS_W)'(0),
                      result.max_dist_sq,
                      result.second_y,
                      result.second_x,
                      result.first_y,
                      result.first_x};

    assign m_tuser = {result.points_dropped, result.pair_found};

endmodule

`default_nettype wire

// ----- design/fps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Farthest pair search controller
// Sequences load, pair scan, drain, fetch of the best pair and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl
    import fps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_last,
    output logic           in_ready,
    input  wire fps_stat_t stat,
    output fps_cmd_t       cmd
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = accept;
                if (accept && in_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_idle)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the previous result has left
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/fps_datapath.sv -----
// ----------------------------------------------------------------------------
// Farthest pair search datapath
// Point memories, pair walk, distance pipeline, best tracker, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_datapath
    import fps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fps_cmd_t cmd,
    input  wire coord_t   in_x,
    input  wire coord_t   in_y,
    input  wire logic     out_ready,
    output logic          out_valid,
    output fps_result_t   result,
    output fps_stat_t     stat
);

    // point storage, two read ports
    coord_t x_mem [MAX_POINTS];
    coord_t y_mem [MAX_POINTS];

    logic [CNT_W-1:0]  count_reg;
    logic              overflow_reg;
    logic [CNT_W-1:0]  a_reg;
    logic [CNT_W-1:0]  b_reg;
    logic [CNT_W-1:0]  a_next;
    logic [CNT_W-1:0]  b_next;

    logic              has_room;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;

    // stage 1: read data
    logic              v1_reg;
    logic [IDX_W-1:0]  ia1_reg;
    logic [IDX_W-1:0]  ib1_reg;
    coord_t            xa_reg;
    coord_t            ya_reg;
    coord_t            xb_reg;
    coord_t            yb_reg;

    // stage 2: absolute differences
    logic signed [COORD_BITS:0] dxs;
    logic signed [COORD_BITS:0] dys;
    logic              v2_reg;
    logic [IDX_W-1:0]  ia2_reg;
    logic [IDX_W-1:0]  ib2_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;

    // stage 3: squares
    logic              v3_reg;
    logic [IDX_W-1:0]  ia3_reg;
    logic [IDX_W-1:0]  ib3_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;

    // compare stage
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_a_reg;
    logic [IDX_W-1:0]  best_b_reg;
    logic              found;

    logic              out_valid_reg;
    fps_result_t       result_reg;

    assign has_room  = (count_reg < CNT_W'(MAX_POINTS));
    assign rd_en     = cmd.scan_run || cmd.fetch;
    assign rd_addr_a = cmd.fetch ? best_a_reg : a_reg[IDX_W-1:0];
    assign rd_addr_b = cmd.fetch ? best_b_reg : b_reg[IDX_W-1:0];

    // advance the pair walk: next b in the row, else next row
    always_comb
    begin
        if (b_reg == count_reg - CNT_W'(1))
        begin
            a_next = a_reg + CNT_W'(1);
            b_next = a_reg + CNT_W'(2);
        end
        else
        begin
            a_next = a_reg;
            b_next = b_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && has_room)
        begin
            x_mem[count_reg[IDX_W-1:0]] <= in_x;
            y_mem[count_reg[IDX_W-1:0]] <= in_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            xa_reg <= x_mem[rd_addr_a];
            ya_reg <= y_mem[rd_addr_a];
            xb_reg <= x_mem[rd_addr_b];
            yb_reg <= y_mem[rd_addr_b];
        end
    end

    assign dxs = $signed({xa_reg[COORD_BITS-1], xa_reg}) - $signed({xb_reg[COORD_BITS-1], xb_reg});
    assign dys = $signed({ya_reg[COORD_BITS-1], ya_reg}) - $signed({yb_reg[COORD_BITS-1], yb_reg});
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign found = (best_reg != '0);

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        ia1_reg <= a_reg[IDX_W-1:0];
        ib1_reg <= b_reg[IDX_W-1:0];
        ia2_reg <= ia1_reg;
        ib2_reg <= ib1_reg;
        dx_reg  <= dxs[COORD_BITS] ? COORD_BITS'(-dxs) : COORD_BITS'(dxs);
        dy_reg  <= dys[COORD_BITS] ? COORD_BITS'(-dys) : COORD_BITS'(dys);
        ia3_reg <= ia2_reg;
        ib3_reg <= ib2_reg;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.first_x        <= found ? xa_reg : '0;
            result_reg.first_y        <= found ? ya_reg : '0;
            result_reg.second_x       <= found ? xb_reg : '0;
            result_reg.second_y       <= found ? yb_reg : '0;
            result_reg.max_dist_sq    <= best_reg;
            result_reg.pair_found     <= found;
            result_reg.points_dropped <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            best_reg      <= '0;
            best_a_reg    <= '0;
            best_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_en)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            else if (cmd.emit)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end

            if (cmd.scan_init)
            begin
                a_reg <= '0;
                b_reg <= CNT_W'(1);
            end
            else if (cmd.scan_run)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
            end

            v1_reg <= cmd.scan_run;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            // strictly greater keeps the first farthest pair
            if (cmd.scan_init)
            begin
                best_reg   <= '0;
                best_a_reg <= '0;
                best_b_reg <= '0;
            end
            else if (v3_reg && (sum > best_reg))
            begin
                best_reg   <= sum;
                best_a_reg <= ia3_reg;
                best_b_reg <= ib3_reg;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_done = (b_reg >= count_reg);
    assign stat.pipe_idle = !v1_reg && !v2_reg && !v3_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign result         = result_reg;

endmodule

`default_nettype wire

// ----- design/fps_checker.sv -----
// ----------------------------------------------------------------------------
// Farthest pair search port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "farthest_pair_search_top_defines.svh"

module fps_checker
    import fps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result holds
    `FPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // no pair: all data fields are zero
    `FPS_ASSERT_NOW(a_nopair_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

    // a found pair has a nonzero distance
    `FPS_ASSERT_NOW(a_pair_dist, m_tvalid && m_tuser[0], m_tdata[M_FIELDS_W-1:4*COORD_BITS] != '0)

    // closing a set stops intake for the search
    `FPS_ASSERT_NEXT(a_last_stops, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind farthest_pair_search_top fps_checker u_fps_checker (.*);

`default_nettype wire
